// ===== rtl/gdt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the gyro drift tracker: shared widths, codes and the
// command, status and configuration types. No dependencies.
package gdt_pkg;

    localparam int AXES       = 3;
    localparam int SQRT_STEPS = 32;   // one root bit per step
    localparam int DIV_STEPS  = 46;   // dividend is weight << 16
    localparam int FAST_MULT  = 45;
    localparam int CNT_W      = 6;

    localparam logic [2:0] REG_GAIN_X      = 3'd0;
    localparam logic [2:0] REG_GAIN_Y      = 3'd1;
    localparam logic [2:0] REG_GAIN_Z      = 3'd2;
    localparam logic [2:0] REG_BASE_WEIGHT = 3'd3;
    localparam logic [2:0] REG_FAST_DRIFT  = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_RATE,
        OP_WB_RATE,
        OP_MUL_SQ,
        OP_ACC_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_CLAMP,
        OP_MUL_UPD,
        OP_WB_UPD,
        OP_PUBLISH
    } gdt_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE_MUL,
        S_RATE_WB,
        S_SQ_MUL,
        S_SQ_ACC,
        S_CHECK,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_CLAMP,
        S_UPD_MUL,
        S_UPD_WB,
        S_PUBLISH
    } gdt_state_t;

    typedef struct packed {
        gdt_op_t    op;
        logic [1:0] axis;
    } gdt_cmd_t;

    typedef struct packed {
        logic big_mag;    // magnitude above 1 dps
        logic out_free;   // result register can take a new result
    } gdt_sts_t;

    typedef struct packed {
        logic [AXES-1:0][31:0] gain;
        logic [23:0]           base_weight;
        logic                  fast_drift;
    } gdt_cfg_t;

endpackage

// ===== rtl/gdt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input samples and results.
// Depends on nothing.
interface gdt_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accum_x;
    logic signed [31:0] accum_y;
    logic signed [31:0] accum_z;

    modport source (output valid, accum_x, accum_y, accum_z, input ready);
    modport sink   (input valid, accum_x, accum_y, accum_z, output ready);
endinterface

interface gdt_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] drift_out_x;
    logic signed [31:0] drift_out_y;
    logic signed [31:0] drift_out_z;

    modport source (output valid, rate_x, rate_y, rate_z,
                    drift_out_x, drift_out_y, drift_out_z, input ready);
    modport sink   (input valid, rate_x, rate_y, rate_z,
                    drift_out_x, drift_out_y, drift_out_z, output ready);
endinterface

// ===== rtl/gdt_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the drift tracker: issues at most one datapath command per
// cycle, waiting while the result register is busy. Depends on gdt_pkg.
module gdt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gdt_pkg::gdt_sts_t sts,
    output gdt_pkg::gdt_cmd_t cmd
);
    import gdt_pkg::*;

    gdt_state_t       state_reg, state_next;
    logic [1:0]       axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // state, axis and step counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    axis_next  = '0;
                    state_next = S_RATE_MUL;
                end
            end
            S_RATE_MUL:
            begin
                cmd.op     = OP_MUL_RATE;
                state_next = S_RATE_WB;
            end
            S_RATE_WB:
            begin
                cmd.op = OP_WB_RATE;
                if (axis_reg == 2'(AXES - 1))
                begin
                    axis_next  = '0;
                    state_next = S_SQ_MUL;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_RATE_MUL;
                end
            end
            S_SQ_MUL:
            begin
                cmd.op     = OP_MUL_SQ;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.op = OP_ACC_SQ;
                if (axis_reg == 2'(AXES - 1))
                begin
                    axis_next  = '0;
                    state_next = S_CHECK;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_SQ_MUL;
                end
            end
            S_CHECK:
            begin
                cnt_next = '0;
                if (sts.big_mag)
                begin
                    cmd.op     = OP_SQRT_INIT;
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_CLAMP;
                end
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.op     = OP_CLAMP;
                axis_next  = '0;
                state_next = S_UPD_MUL;
            end
            S_UPD_MUL:
            begin
                cmd.op     = OP_MUL_UPD;
                state_next = S_UPD_WB;
            end
            S_UPD_WB:
            begin
                cmd.op = OP_WB_UPD;
                if (axis_reg == 2'(AXES - 1))
                begin
                    axis_next  = '0;
                    state_next = S_PUBLISH;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_UPD_MUL;
                end
            end
            S_PUBLISH:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/gdt_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: shared 33x33 multiplier, root and divide units, drift state
// and the result register. Depends on gdt_pkg.
module gdt_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gdt_pkg::gdt_cmd_t       cmd,
    output gdt_pkg::gdt_sts_t       sts,
    input  gdt_pkg::gdt_cfg_t       cfg,
    input  logic signed [2:0][31:0] accum,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [2:0][31:0] out_rate,
    output logic signed [2:0][31:0] out_drift
);
    import gdt_pkg::*;

    localparam logic [63:0] ONE_DPS_SQ = 64'h1_0000_0000;
    localparam logic [45:0] ONE_Q24    = 46'd16777216;

    logic signed [2:0][31:0] accum_reg;
    logic signed [2:0][31:0] rate_reg;
    logic signed [2:0][31:0] drift_reg;
    logic signed [2:0][31:0] res_rate_reg;
    logic signed [2:0][31:0] out_rate_reg;
    logic signed [2:0][31:0] out_drift_reg;
    logic                    out_valid_reg;
    logic signed [65:0]      prod_reg;
    logic [63:0]             sumsq_reg;
    logic [29:0]             w_reg;
    logic [63:0]             rad_reg;
    logic [31:0]             root_reg;
    logic [35:0]             srem_reg;
    logic [45:0]             dvd_reg;
    logic [31:0]             drem_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [32:0] diff;
    logic signed [65:0] rnd_rate;
    logic signed [65:0] rnd_upd;
    logic signed [33:0] inc;
    logic signed [33:0] nd;
    logic signed [33:0] corr;
    logic signed [31:0] rate_sat;
    logic signed [31:0] corr_sat;
    logic [35:0]        srem_sh;
    logic [35:0]        trial;
    logic [32:0]        drem_sh;
    logic [45:0]        w_src;
    logic [29:0]        w_base;

    assign sts.big_mag  = (sumsq_reg > ONE_DPS_SQ);
    assign sts.out_free = !out_valid_reg || out_ready;

    // multiplier operand selection; element selects are unsigned, so sign-extend
    assign diff = 33'($signed(rate_reg[cmd.axis])) - 33'($signed(drift_reg[cmd.axis]));
    always_comb
    begin
        mul_a = 33'($signed(accum_reg[cmd.axis]));
        mul_b = {1'b0, cfg.gain[cmd.axis]};
        if (cmd.op == OP_MUL_SQ)
        begin
            mul_a = 33'($signed(rate_reg[cmd.axis]));
            mul_b = 33'($signed(rate_reg[cmd.axis]));
        end
        else if (cmd.op == OP_MUL_UPD)
        begin
            mul_a = {3'b000, w_reg};
            mul_b = diff;
        end
    end

    // rate: round half up by 2^8, then saturate
    assign rnd_rate = (prod_reg + 66'sd128) >>> 8;
    always_comb
    begin
        if (rnd_rate > 66'sd2147483647)
            rate_sat = 32'sh7FFF_FFFF;
        else if (rnd_rate < -66'sd2147483648)
            rate_sat = 32'sh8000_0000;
        else
            rate_sat = rnd_rate[31:0];
    end

    // drift update: round half up by 2^24; new drift lies between old and rate
    assign rnd_upd = (prod_reg + 66'sd8388608) >>> 24;
    assign inc     = rnd_upd[33:0];
    assign nd      = 34'($signed(drift_reg[cmd.axis])) + inc;
    assign corr    = 34'($signed(rate_reg[cmd.axis])) - nd;
    always_comb
    begin
        if (corr > 34'sd2147483647)
            corr_sat = 32'sh7FFF_FFFF;
        else if (corr < -34'sd2147483648)
            corr_sat = 32'sh8000_0000;
        else
            corr_sat = corr[31:0];
    end

    // root and divide step terms
    assign srem_sh = {srem_reg[33:0], rad_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign drem_sh = {drem_reg, dvd_reg[45]};
    assign w_src   = sts.big_mag ? dvd_reg : {16'd0, w_reg};
    assign w_base  = cfg.fast_drift ? ({6'd0, cfg.base_weight} * 30'(FAST_MULT))
                                    : {6'd0, cfg.base_weight};

    // work registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                accum_reg <= accum;
                sumsq_reg <= '0;
                w_reg     <= w_base;
            end
            OP_MUL_RATE, OP_MUL_SQ, OP_MUL_UPD:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_WB_RATE:
            begin
                rate_reg[cmd.axis] <= rate_sat;
            end
            OP_ACC_SQ:
            begin
                sumsq_reg <= sumsq_reg + prod_reg[63:0];
            end
            OP_SQRT_INIT:
            begin
                rad_reg  <= sumsq_reg;
                root_reg <= '0;
                srem_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                rad_reg <= {rad_reg[61:0], 2'b00};
                if (srem_sh >= trial)
                begin
                    srem_reg <= srem_sh - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            OP_DIV_INIT:
            begin
                dvd_reg  <= {w_reg, 16'd0};
                drem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                if (drem_sh >= {1'b0, root_reg})
                begin
                    drem_reg <= 32'(drem_sh - {1'b0, root_reg});
                    dvd_reg  <= {dvd_reg[44:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh[31:0];
                    dvd_reg  <= {dvd_reg[44:0], 1'b0};
                end
            end
            OP_CLAMP:
            begin
                w_reg <= (w_src > ONE_Q24) ? ONE_Q24[29:0] : w_src[29:0];
            end
            OP_WB_UPD:
            begin
                res_rate_reg[cmd.axis] <= corr_sat;
            end
            OP_PUBLISH:
            begin
                out_rate_reg  <= res_rate_reg;
                out_drift_reg <= drift_reg;
            end
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // drift state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_WB_UPD)
                drift_reg[cmd.axis] <= nd[31:0];
            if (cmd.op == OP_PUBLISH)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rate  = out_rate_reg;
    assign out_drift = out_drift_reg;

endmodule

// ===== rtl/gyro_drift_tracker_core.sv =====
`timescale 1ns / 1ps
// Gyro drift tracker: one three-axis sample in, one drift-corrected rate
// and drift estimate out. When the rate magnitude is above 1 dps, the
// bit-serial square root (32 steps) and restoring divide (46 steps) run
// before the update; the shared multiplier does scale, square and update
// for each axis. The next sample is taken as soon as the result sits in
// the output register. Configuration must be written by the user only
// while idle; the block itself does not enforce this.
module gyro_drift_tracker_core (
    input  logic         clk,
    input  logic         rst_n,
    gdt_sample_if.sink   sample,
    gdt_result_if.source result,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import gdt_pkg::*;

    gdt_cfg_t                cfg_reg;
    gdt_cmd_t                cmd;
    gdt_sts_t                sts;
    logic signed [2:0][31:0] accum;
    logic signed [2:0][31:0] out_rate;
    logic signed [2:0][31:0] out_drift;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                REG_GAIN_X:      cfg_reg.gain[0]     <= cfg_data;
                REG_GAIN_Y:      cfg_reg.gain[1]     <= cfg_data;
                REG_GAIN_Z:      cfg_reg.gain[2]     <= cfg_data;
                REG_BASE_WEIGHT: cfg_reg.base_weight <= cfg_data[23:0];
                REG_FAST_DRIFT:  cfg_reg.fast_drift  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign accum = {sample.accum_z, sample.accum_y, sample.accum_x};

    gdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gdt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg       (cfg_reg),
        .accum     (accum),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_rate  (out_rate),
        .out_drift (out_drift)
    );

    assign result.rate_x      = out_rate[0];
    assign result.rate_y      = out_rate[1];
    assign result.rate_z      = out_rate[2];
    assign result.drift_out_x = out_drift[0];
    assign result.drift_out_y = out_drift[1];
    assign result.drift_out_z = out_drift[2];

endmodule

// ===== rtl/gdt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the drift tracker, bound to the top level.
// Depends on gyro_drift_tracker_core and the channel interfaces.
module gdt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_rate_x,
    input logic [31:0] out_drift_x
);
    // a stalled result keeps its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its x-axis rate and drift payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_rate_x) && $stable(out_drift_x))
        else $error("result payload changed while stalled");

    // one sample in work at a time
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while busy");

    // no result appears in the cycle after a sample transfer made while none is pending
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");
endmodule

bind gyro_drift_tracker_core gdt_checker u_gdt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_rate_x  (result.rate_x),
    .out_drift_x (result.drift_out_x)
);
